// ----- src/sia_pkg.sv -----
// Shared types, codes, constants and microcode table of the stack integer ALU.
`default_nettype none

package sia_pkg;

    localparam int unsigned DataW         = 32;
    localparam int unsigned DepthOutW     = 7;
    localparam int unsigned StackDepthDef = 64;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Sequencer jump kinds
    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_EXEC,
        J_WAIT_DIV,
        J_WAIT_OUT
    } t_jump;

    localparam int unsigned PcW = 3;
    typedef logic [PcW-1:0] t_pc;

    localparam t_pc PC_FETCH = 3'd0;
    localparam t_pc PC_PUSH  = 3'd1;
    localparam t_pc PC_READ  = 3'd2;
    localparam t_pc PC_EXEC  = 3'd3;
    localparam t_pc PC_DIVW  = 3'd4;
    localparam t_pc PC_OUT   = 3'd5;

    typedef struct packed {
        logic  ready;   // accept an input beat in this step
        logic  rd;      // read the second entry from the stack RAM
        logic  push;    // spill the cached top and load the pushed value
        t_jump jump;
        t_pc   target;
    } t_ctl;

    // Microcode ROM: one control word per step
    function automatic t_ctl ucode(t_pc pc);
        t_ctl c;
        c = '0;
        unique case (pc)
            PC_FETCH: begin
                c.ready  = 1'b1;
                c.jump   = J_DISPATCH;
                c.target = PC_FETCH;
            end
            PC_PUSH: begin
                c.push   = 1'b1;
                c.jump   = J_GOTO;
                c.target = PC_OUT;
            end
            PC_READ: begin
                c.rd     = 1'b1;
                c.jump   = J_NEXT;
                c.target = PC_EXEC;
            end
            PC_EXEC: begin
                c.jump   = J_EXEC;
                c.target = PC_OUT;
            end
            PC_DIVW: begin
                c.jump   = J_WAIT_DIV;
                c.target = PC_OUT;
            end
            PC_OUT: begin
                c.jump   = J_WAIT_OUT;
                c.target = PC_FETCH;
            end
            default: begin
                c.jump   = J_GOTO;
                c.target = PC_FETCH;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/sia_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sia_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/sia_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module sia_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [sia_pkg::DataW-1:0] i_dividend,
    input  wire logic [sia_pkg::DataW-1:0] i_divisor,
    output logic                           o_done,
    output logic      [sia_pkg::DataW-1:0] o_quotient,
    output logic      [sia_pkg::DataW-1:0] o_remainder
);

    localparam int unsigned W    = sia_pkg::DataW;
    localparam int unsigned CntW = $clog2(W);

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_den;
    logic            r_neg_q;
    logic            r_neg_r;

    logic [W:0]      shifted;
    logic [W:0]      diff;
    logic [W-1:0]    abs_num;
    logic [W-1:0]    abs_den;

    assign abs_num = i_dividend[W-1] ? (~i_dividend + W'(1)) : i_dividend;
    assign abs_den = i_divisor[W-1]  ? (~i_divisor  + W'(1)) : i_divisor;

    // Restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CntW'(W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= '0;
            r_quo   <= abs_num;
            r_rem   <= '0;
            r_den   <= abs_den;
            r_neg_q <= i_dividend[W-1] ^ i_divisor[W-1];
            r_neg_r <= i_dividend[W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + CntW'(1);
            r_quo <= {r_quo[W-2:0], ~diff[W]};
            r_rem <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? (~r_quo + W'(1)) : r_quo;
    assign o_remainder = r_neg_r ? (~r_rem + W'(1)) : r_rem;

endmodule

`default_nettype wire

// ----- src/stack_integer_alu.sv -----
// Top level of the stack integer ALU: microcoded sequencer, stack RAM and datapath.
`default_nettype none

// Stack machine arithmetic unit over a bounded stack of STACK_DEPTH signed 32-bit
// entries. Each input beat carries one opcode (tuser) and a push value (tdata);
// each beat yields exactly one result beat with status (tuser), the top of stack
// after the step (zero when empty) and the entry count modulo 128 (tdata). Push
// places the value on top; add, sub, mul, div and mod pop the top t and replace
// the second entry s by s op t, wrapping modulo 2^32, division truncating toward
// zero, remainder taking the dividend's sign, min / -1 giving min. Too few
// entries, a zero divisor or a push onto a full stack report an error and leave
// the stack as it was; opcodes 6 and 7 do nothing and report ok. The top entry
// lives in a register and the rest in a RAM, so an operation reads only the
// second entry. Items are handled one at a time by a six-step microprogram;
// a new beat is accepted only after the previous result has been loaded into
// the output register, and div and mod first wait on the divider, which
// produces one quotient bit per cycle. A finished result waits in the output
// register while the next beat is accepted. The stack RAM needs no clearing
// after reset.
module stack_integer_alu #(
    parameter int unsigned STACK_DEPTH = sia_pkg::StackDepthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [31:0] push_value
    input  wire logic [2:0]  i_s_axis_tuser,  // [2:0] opcode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [39:0] o_m_axis_tdata,  // [31:0] top_value, [38:32] depth_after
    output logic      [1:0]  o_m_axis_tuser   // [1:0] status
);

    localparam int unsigned W     = sia_pkg::DataW;
    localparam int unsigned DW    = sia_pkg::DepthOutW;
    localparam int unsigned AddrW = $clog2(STACK_DEPTH);
    localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

    // Sequencer and control state
    sia_pkg::t_pc     r_pc,          n_pc;
    logic [CntW-1:0]  r_count,       n_count;
    logic             r_out_valid,   n_out_valid;

    // Payload registers
    sia_pkg::t_opcode r_op,          n_op;
    logic [W-1:0]     r_pv,          n_pv;
    sia_pkg::t_status r_status,      n_status;
    logic [W-1:0]     r_top,         n_top;
    sia_pkg::t_status r_out_status,  n_out_status;
    logic [W-1:0]     r_out_top,     n_out_top;
    logic [DW-1:0]    r_out_depth,   n_out_depth;

    sia_pkg::t_ctl    ctl;
    logic             beat_in;
    logic             is_full;
    logic             is_short;
    logic             is_divop;

    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [AddrW-1:0] ram_raddr;
    logic [W-1:0]     ram_rdata;

    logic             div_start;
    logic             div_done;
    logic [W-1:0]     div_quo;
    logic [W-1:0]     div_rem;

    logic [W-1:0]     alu_sum;
    logic [W-1:0]     alu_diff;
    logic [W-1:0]     alu_prod;
    logic [CntW+DW-1:0] count_ext;

    assign ctl      = sia_pkg::ucode(r_pc);
    assign beat_in  = i_s_axis_tvalid && ctl.ready;
    assign is_full  = (r_count == CntW'(STACK_DEPTH));
    assign is_short = (r_count < CntW'(2));
    assign is_divop = (r_op == sia_pkg::OP_DIV) || (r_op == sia_pkg::OP_MOD);

    // Top sits in r_top; entry below it is at count-2, a spill goes to count-1
    assign ram_waddr = AddrW'(r_count - CntW'(1));
    assign ram_raddr = AddrW'(r_count - CntW'(2));
    assign ram_we    = ctl.push && (r_count != '0);

    // Second entry comes from RAM, top from the cache register
    assign alu_sum   = ram_rdata + r_top;
    assign alu_diff  = ram_rdata - r_top;
    assign alu_prod  = ram_rdata * r_top;

    assign count_ext = {{DW{1'b0}}, r_count};

    sia_ram #(
        .Width (W),
        .Depth (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_top),
        .i_re    (ctl.rd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sia_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (ram_rdata),
        .i_divisor   (r_top),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_pc         = r_pc;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_pv         = r_pv;
        n_status     = r_status;
        n_top        = r_top;
        n_out_status = r_out_status;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        div_start    = 1'b0;

        // Drop the result once the downstream side takes it
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Push: old top spills into the RAM, new value becomes the top
        if (ctl.push) begin
            n_top   = r_pv;
            n_count = r_count + CntW'(1);
        end

        unique case (ctl.jump)
            sia_pkg::J_NEXT: begin
                n_pc = r_pc + sia_pkg::PcW'(1);
            end
            sia_pkg::J_GOTO: begin
                n_pc = ctl.target;
            end
            sia_pkg::J_DISPATCH: begin
                // Hold in fetch until a beat arrives, then check depth and branch
                if (beat_in) begin
                    n_op     = sia_pkg::t_opcode'(i_s_axis_tuser);
                    n_pv     = i_s_axis_tdata;
                    n_status = sia_pkg::ST_OK;
                    n_pc     = sia_pkg::PC_OUT;
                    unique case (i_s_axis_tuser)
                        sia_pkg::OP_PUSH: begin
                            if (is_full) begin
                                n_status = sia_pkg::ST_FULL;
                            end else begin
                                n_pc = sia_pkg::PC_PUSH;
                            end
                        end
                        sia_pkg::OP_ADD, sia_pkg::OP_SUB, sia_pkg::OP_MUL,
                        sia_pkg::OP_DIV, sia_pkg::OP_MOD: begin
                            if (is_short) begin
                                n_status = sia_pkg::ST_SHORT;
                            end else begin
                                n_pc = sia_pkg::PC_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sia_pkg::J_EXEC: begin
                n_pc = ctl.target;
                if (is_divop) begin
                    if (r_top == '0) begin
                        n_status = sia_pkg::ST_DIVZERO;
                    end else begin
                        div_start = 1'b1;
                        n_pc      = sia_pkg::PC_DIVW;
                    end
                end else begin
                    unique case (r_op)
                        sia_pkg::OP_ADD: n_top = alu_sum;
                        sia_pkg::OP_SUB: n_top = alu_diff;
                        default:         n_top = alu_prod;
                    endcase
                    n_count = r_count - CntW'(1);
                end
            end
            sia_pkg::J_WAIT_DIV: begin
                if (div_done) begin
                    n_top   = (r_op == sia_pkg::OP_DIV) ? div_quo : div_rem;
                    n_count = r_count - CntW'(1);
                    n_pc    = ctl.target;
                end
            end
            sia_pkg::J_WAIT_OUT: begin
                // Load the output register as soon as it is free or being drained
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_top    = (r_count == '0) ? '0 : r_top;
                    n_out_depth  = count_ext[DW-1:0];
                    n_pc         = ctl.target;
                end
            end
            default: begin
                n_pc = sia_pkg::PC_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= sia_pkg::PC_FETCH;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_pv         <= n_pv;
        r_status     <= n_status;
        r_top        <= n_top;
        r_out_status <= n_out_status;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
    end

    assign o_s_axis_tready = ctl.ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {1'b0, r_out_depth, r_out_top};

    // The stack never holds more entries than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(STACK_DEPTH))
        else $error("stack count exceeds depth");

    // An accepted beat always moves the sequencer out of fetch
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat_in |=> r_pc != sia_pkg::PC_FETCH)
        else $error("sequencer stayed in fetch after an accepted beat");

    // Entry count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
                            || r_count == $past(r_count) + CntW'(1)
                            || r_count == $past(r_count) - CntW'(1)))
        else $error("stack count jumped by more than one");

    // A divider result only arrives while the sequencer waits for it
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_pc == sia_pkg::PC_DIVW)
        else $error("divider finished outside the wait step");

endmodule

`default_nettype wire
